FILE: hw/rtl/idtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_pkg: shared types and constants of the image diff tolerance check
// Channel widths, register indexes, lane and result structs.
// ----------------------------------------------------------------------------
package idtc_pkg;

   // fixed pixel format: four byte channels per beat
   localparam int NUM_CH     = 4;
   localparam int CH_W       = 8;
   localparam int FAIL_IDX_W = 24;
   localparam int CHAN_CNT_W = 3;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS  = 8'd1;

   // reset values and marking color
   localparam logic [CH_W-1:0]       TOL_RESET  = 8'd0;
   localparam logic [CHAN_CNT_W-1:0] CHAN_RESET = 3'd4;
   localparam logic [CH_W-1:0]       FAIL_COLOR = 8'hff;

   typedef logic [CH_W-1:0] chan_byte_type;

   // what one lane reports to the merge stage
   typedef struct packed {
      chan_byte_type delta;
      logic          exceed;
   } lane_res_type;

   // one result beat
   typedef struct packed {
      chan_byte_type [NUM_CH-1:0] delta;
      chan_byte_type [NUM_CH-1:0] marked;
      logic                       pixel_breach;
      logic                       image_pass_so_far;
      logic [FAIL_IDX_W-1:0]      first_fail_pixel;
      logic                       end_of_image_out;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hw/rtl/idtc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_if: channel interfaces of the image diff tolerance check
// Pixel pair request, compare response and register write channels.
// ----------------------------------------------------------------------------

// pixel pair request channel
interface idtc_req_if;
   logic valid;
   logic ready;
   logic [idtc_pkg::CH_W-1:0] test_c0;
   logic [idtc_pkg::CH_W-1:0] test_c1;
   logic [idtc_pkg::CH_W-1:0] test_c2;
   logic [idtc_pkg::CH_W-1:0] test_c3;
   logic [idtc_pkg::CH_W-1:0] base_c0;
   logic [idtc_pkg::CH_W-1:0] base_c1;
   logic [idtc_pkg::CH_W-1:0] base_c2;
   logic [idtc_pkg::CH_W-1:0] base_c3;
   logic end_of_image;

   modport source (output valid, test_c0, test_c1, test_c2, test_c3,
                   base_c0, base_c1, base_c2, base_c3, end_of_image,
                   input ready);
   modport sink   (input valid, test_c0, test_c1, test_c2, test_c3,
                   base_c0, base_c1, base_c2, base_c3, end_of_image,
                   output ready);
endinterface

// compare result channel
interface idtc_rsp_if;
   logic valid;
   logic ready;
   logic [idtc_pkg::CH_W-1:0] delta_c0;
   logic [idtc_pkg::CH_W-1:0] delta_c1;
   logic [idtc_pkg::CH_W-1:0] delta_c2;
   logic [idtc_pkg::CH_W-1:0] delta_c3;
   logic [idtc_pkg::CH_W-1:0] marked_c0;
   logic [idtc_pkg::CH_W-1:0] marked_c1;
   logic [idtc_pkg::CH_W-1:0] marked_c2;
   logic [idtc_pkg::CH_W-1:0] marked_c3;
   logic pixel_breach;
   logic image_pass_so_far;
   logic [idtc_pkg::FAIL_IDX_W-1:0] first_fail_pixel;
   logic end_of_image_out;

   modport source (output valid, delta_c0, delta_c1, delta_c2, delta_c3,
                   marked_c0, marked_c1, marked_c2, marked_c3, pixel_breach,
                   image_pass_so_far, first_fail_pixel, end_of_image_out,
                   input ready);
   modport sink   (input valid, delta_c0, delta_c1, delta_c2, delta_c3,
                   marked_c0, marked_c1, marked_c2, marked_c3, pixel_breach,
                   image_pass_so_far, first_fail_pixel, end_of_image_out,
                   output ready);
endinterface

// register write channel
interface idtc_csr_if;
   logic valid;
   logic ready;
   logic [idtc_pkg::CSR_IDX_W-1:0]  index;
   logic [idtc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/idtc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_lane: one channel compare lane
// Absolute byte difference and tolerance test for one channel.
// ----------------------------------------------------------------------------
module idtc_lane (
   input  wire logic [idtc_pkg::CH_W-1:0] test_byte,
   input  wire logic [idtc_pkg::CH_W-1:0] base_byte,
   input  wire logic                      active,
   input  wire logic [idtc_pkg::CH_W-1:0] tolerance,
   output idtc_pkg::lane_res_type         lane_res
);

   logic [idtc_pkg::CH_W-1:0] abs_diff;

   // |test - base|
   assign abs_diff = (test_byte > base_byte) ? (test_byte - base_byte)
                                             : (base_byte - test_byte);

   // inactive channels read zero and never fail
   assign lane_res.delta  = active ? abs_diff : '0;
   assign lane_res.exceed = active && (abs_diff > tolerance);

endmodule
`default_nettype wire

FILE: hw/rtl/idtc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idtc_merge: lane merge and image tracking
// ORs lane breaches, builds the marked pixel and keeps the per-image
// pass flag, pixel index and first failing index.
// ----------------------------------------------------------------------------
module idtc_merge #(
   parameter int PIXEL_INDEX_BITS = 24
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      accept,
   input  wire logic                                      end_of_image,
   input  wire logic [idtc_pkg::NUM_CH-1:0]               active,
   input  idtc_pkg::lane_res_type [idtc_pkg::NUM_CH-1:0]  lane_res,
   output idtc_pkg::rsp_type                              result
);

   logic                        pass_ff,  pass_in;
   logic [PIXEL_INDEX_BITS-1:0] count_ff, count_in;
   logic [PIXEL_INDEX_BITS-1:0] first_ff, first_in;

   logic                        breach;
   logic                        pass_now;
   logic [PIXEL_INDEX_BITS-1:0] first_now;
   logic [31:0]                 first_wide;

   // breach if any lane exceeded
   always_comb begin
      breach = 1'b0;
      for (int c = 0; c < idtc_pkg::NUM_CH; c++) begin
         breach = breach | lane_res[c].exceed;
      end
   end

   // running state including this pixel
   assign pass_now   = pass_ff & ~breach;
   assign first_now  = (pass_ff && breach) ? count_ff : first_ff;
   assign first_wide = 32'(first_now);

   // result fields
   always_comb begin
      for (int c = 0; c < idtc_pkg::NUM_CH; c++) begin
         result.delta[c]  = lane_res[c].delta;
         result.marked[c] = (active[c] && breach) ? idtc_pkg::FAIL_COLOR
                                                  : lane_res[c].delta;
      end
      result.pixel_breach      = breach;
      result.image_pass_so_far = pass_now;
      result.first_fail_pixel  = pass_now ? '0
                                 : first_wide[idtc_pkg::FAIL_IDX_W-1:0];
      result.end_of_image_out  = end_of_image;
   end

   // next state on an accepted beat: end of image clears, else advance the pixel index
   always_comb begin
      pass_in  = pass_ff;
      count_in = count_ff;
      first_in = first_ff;
      if (accept) begin
         if (end_of_image) begin
            pass_in  = 1'b1;
            count_in = '0;
            first_in = '0;
         end else begin
            pass_in  = pass_now;
            count_in = count_ff + 1'b1;
            first_in = first_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff  <= 1'b1;
         count_ff <= '0;
         first_ff <= '0;
      end else begin
         pass_ff  <= pass_in;
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/image_diff_tolerance_check_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_diff_tolerance_check_core: pixel pair compare against a tolerance
// Takes one test/baseline pixel pair per clock while ready and returns channel deltas,
// a marked pixel and the running pass state of the image.
// ----------------------------------------------------------------------------
// A pixel pair is taken every clock while the request side is ready. The
// channel lanes compute all differences in parallel and the merge stage
// combines them in the same cycle into the result register, so the sustained
// rate is one pixel per clock while the response side does not stall. A
// two-entry result buffer keeps the request side ready for one further beat
// while the response side stalls. Register writes take effect on the next
// beat; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module image_diff_tolerance_check_core #(
   parameter int MAX_CHANNELS     = 4,
   parameter int PIXEL_INDEX_BITS = 24
) (
   input  wire logic   clock,
   input  wire logic   reset,
   idtc_req_if.sink    req_ch,
   idtc_rsp_if.source  rsp_ch,
   idtc_csr_if.sink    csr_ch
);

   localparam logic [idtc_pkg::CHAN_CNT_W-1:0] MAX_CNT =
      idtc_pkg::CHAN_CNT_W'(MAX_CHANNELS);

   // configuration registers
   logic [idtc_pkg::CH_W-1:0]       tol_ff,  tol_in;
   logic [idtc_pkg::CHAN_CNT_W-1:0] chan_ff, chan_in;

   // result buffer
   logic               out_valid_ff,  out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   idtc_pkg::rsp_type  out_ff,  out_in;
   idtc_pkg::rsp_type  skid_ff, skid_in;

   logic                                        req_fire;
   logic                                        rsp_fire;
   logic [idtc_pkg::CHAN_CNT_W-1:0]             act_cnt;
   logic [idtc_pkg::NUM_CH-1:0]                 active;
   idtc_pkg::chan_byte_type [idtc_pkg::NUM_CH-1:0] test_px;
   idtc_pkg::chan_byte_type [idtc_pkg::NUM_CH-1:0] base_px;
   idtc_pkg::lane_res_type  [idtc_pkg::NUM_CH-1:0] lane_res;
   idtc_pkg::rsp_type                           new_rsp;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      tol_in  = tol_ff;
      chan_in = chan_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            idtc_pkg::CSR_TOLERANCE: tol_in  = csr_ch.data;
            idtc_pkg::CSR_CHANNELS:  chan_in = csr_ch.data[idtc_pkg::CHAN_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= idtc_pkg::TOL_RESET;
         chan_ff <= idtc_pkg::CHAN_RESET;
      end else begin
         tol_ff  <= tol_in;
         chan_ff <= chan_in;
      end
   end

   // handshakes
   assign req_ch.ready = ~skid_valid_ff;
   assign req_fire     = req_ch.valid & ~skid_valid_ff;
   assign rsp_fire     = out_valid_ff & rsp_ch.ready;

   // active channel mask, count saturated to the lane count
   assign act_cnt = (chan_ff > MAX_CNT) ? MAX_CNT : chan_ff;

   always_comb begin
      for (int c = 0; c < idtc_pkg::NUM_CH; c++) begin
         active[c] = (idtc_pkg::CHAN_CNT_W'(c) < act_cnt);
      end
   end

   assign test_px = {req_ch.test_c3, req_ch.test_c2, req_ch.test_c1, req_ch.test_c0};
   assign base_px = {req_ch.base_c3, req_ch.base_c2, req_ch.base_c1, req_ch.base_c0};

   // channel lanes; channels past the lane count read zero
   for (genvar g = 0; g < idtc_pkg::NUM_CH; g++) begin : g_lane
      if (g < MAX_CHANNELS) begin : g_on
         idtc_lane u_lane (
            .test_byte (test_px[g]),
            .base_byte (base_px[g]),
            .active    (active[g]),
            .tolerance (tol_ff),
            .lane_res  (lane_res[g])
         );
      end else begin : g_off
         assign lane_res[g] = '0;
      end
   end

   // merge lanes and track the image
   idtc_merge #(
      .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_fire),
      .end_of_image (req_ch.end_of_image),
      .active       (active),
      .lane_res     (lane_res),
      .result       (new_rsp)
   );

   // two-entry result buffer: output register plus skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (rsp_fire || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_rsp;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // response fields
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.delta_c0          = out_ff.delta[0];
   assign rsp_ch.delta_c1          = out_ff.delta[1];
   assign rsp_ch.delta_c2          = out_ff.delta[2];
   assign rsp_ch.delta_c3          = out_ff.delta[3];
   assign rsp_ch.marked_c0         = out_ff.marked[0];
   assign rsp_ch.marked_c1         = out_ff.marked[1];
   assign rsp_ch.marked_c2         = out_ff.marked[2];
   assign rsp_ch.marked_c3         = out_ff.marked[3];
   assign rsp_ch.pixel_breach      = out_ff.pixel_breach;
   assign rsp_ch.image_pass_so_far = out_ff.image_pass_so_far;
   assign rsp_ch.first_fail_pixel  = out_ff.first_fail_pixel;
   assign rsp_ch.end_of_image_out  = out_ff.end_of_image_out;

   // skid entry only ever sits behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   // an accepted beat always shows up on the output side
   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> out_valid_ff)
      else $error("accepted beat not buffered");

   // a breaching pixel can never leave the image passing
   a_breach_fails: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.pixel_breach |-> !out_ff.image_pass_so_far)
      else $error("breach reported with image still passing");

   // passing image reports index zero
   a_pass_zero_idx: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.image_pass_so_far |-> out_ff.first_fail_pixel == '0)
      else $error("nonzero fail index on passing image");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for image_diff_tolerance_check_core
// Streams test/baseline pixel pairs with random gaps and response stalls. A
// scoreboard predicts the channel deltas, the marked pixel and the running
// image state, and checks every result beat against that prediction. The
// run sweeps tolerance and channel count between images.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CH        = 4;
   localparam int PIX_BITS      = 24;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_PIXELS  = 90;
   localparam int CYCLE_LIMIT   = 500000;
   // index that maps to no register; a write there must change nothing
   localparam logic [idtc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 8'hff;

   typedef struct packed {
      idtc_pkg::chan_byte_type [idtc_pkg::NUM_CH-1:0] test;
      idtc_pkg::chan_byte_type [idtc_pkg::NUM_CH-1:0] base;
      logic                                           eoi;
   } pixel_pair_type;

   logic clock = 1'b0;
   logic reset;

   idtc_req_if req_ch ();
   idtc_rsp_if rsp_ch ();
   idtc_csr_if csr_ch ();

   image_diff_tolerance_check_core #(
      .MAX_CHANNELS     (MAX_CH),
      .PIXEL_INDEX_BITS (PIX_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5ns clock = ~clock;

   // pixels waiting to go out, and predicted results waiting to come back
   pixel_pair_type    pixel_queue[$];
   idtc_pkg::rsp_type expected_results[$];

   // register shadow and running image state of the predictor
   idtc_pkg::chan_byte_type         tol_cfg    = idtc_pkg::TOL_RESET;
   logic [idtc_pkg::CHAN_CNT_W-1:0] chan_cfg   = idtc_pkg::CHAN_RESET;
   logic                            img_pass   = 1'b1;
   logic [PIX_BITS-1:0]             pix_index  = '0;
   logic [PIX_BITS-1:0]             fail_index = '0;

   bit          failed    = 1'b0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;
   int          req_gap;
   int          rsp_stall;
   int unsigned cycle_count = 0;

   // idle cycles before the next beat; a calm side never waits
   function automatic int draw_wait(bit calm);
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   // expected result of one pixel pair; advances the image state
   function automatic idtc_pkg::rsp_type compare_pixel(pixel_pair_type px);
      idtc_pkg::rsp_type       r;
      int                      lanes;
      logic                    hit;
      idtc_pkg::chan_byte_type d;
      r     = '0;
      hit   = 1'b0;
      lanes = (chan_cfg > MAX_CH) ? MAX_CH : chan_cfg;
      for (int c = 0; c < idtc_pkg::NUM_CH; c++) begin
         if (c < lanes) begin
            d = (px.test[c] > px.base[c]) ? px.test[c] - px.base[c]
                                          : px.base[c] - px.test[c];
            r.delta[c] = d;
            if (d > tol_cfg) hit = 1'b1;
         end
      end
      if (hit && img_pass) begin
         img_pass   = 1'b0;
         fail_index = pix_index;
      end
      for (int c = 0; c < idtc_pkg::NUM_CH; c++)
         r.marked[c] = (c < lanes && hit) ? idtc_pkg::FAIL_COLOR : r.delta[c];
      r.pixel_breach      = hit;
      r.image_pass_so_far = img_pass;
      r.first_fail_pixel  = img_pass ? '0 : fail_index[idtc_pkg::FAIL_IDX_W-1:0];
      r.end_of_image_out  = px.eoi;
      // image closes after its last result
      if (px.eoi) begin
         img_pass   = 1'b1;
         pix_index  = '0;
         fail_index = '0;
      end else begin
         pix_index = pix_index + 1'b1;
      end
      return r;
   endfunction

   // random pair; a clean pair stays within tolerance on every channel
   function automatic pixel_pair_type make_pair(bit clean);
      pixel_pair_type px;
      int             span;
      int             lo;
      px = '0;
      for (int c = 0; c < idtc_pkg::NUM_CH; c++) begin
         if (clean) begin
            span = $urandom_range(0, tol_cfg);
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  span = $urandom_range(0, tol_cfg);
               end
               1: begin
                  // right at the tolerance or one above it
                  span = tol_cfg + $urandom_range(0, 1);
               end
               default: begin
                  span = -1;
               end
            endcase
         end
         if (span < 0 || span > 255) begin
            px.test[c] = $urandom;
            px.base[c] = $urandom;
         end else begin
            lo = $urandom_range(0, 255 - span);
            if ($urandom_range(0, 1)) begin
               px.test[c] = lo + span;
               px.base[c] = lo;
            end else begin
               px.test[c] = lo;
               px.base[c] = lo + span;
            end
         end
      end
      return px;
   endfunction

   task automatic add_pair(input logic [31:0] t, input logic [31:0] b, input logic eoi);
      pixel_pair_type px;
      px.test = t;
      px.base = b;
      px.eoi  = eoi;
      pixel_queue.push_back(px);
   endtask

   // images of random length, half of them clean with at most one bad pixel
   task automatic queue_images(input int n_pixels);
      int             left;
      int             len;
      int             bad_at;
      bit             clean;
      pixel_pair_type px;
      left = n_pixels;
      while (left > 0) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         if (len > left) len = left;
         clean  = $urandom_range(0, 1);
         bad_at = (clean && $urandom_range(0, 1)) ? $urandom_range(0, len - 1) : -1;
         for (int k = 0; k < len; k++) begin
            px     = make_pair(clean && k != bad_at);
            px.eoi = (k == len - 1);
            pixel_queue.push_back(px);
         end
         left -= len;
      end
   endtask

   // no pixel queued, on the wire or awaiting its result; checked on the
   // falling edge so the driver and monitor updates of the rising edge settle
   task automatic wait_idle();
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [idtc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [idtc_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == idtc_pkg::CSR_TOLERANCE) tol_cfg = val;
      else if (idx == idtc_pkg::CSR_CHANNELS) chan_cfg = val[idtc_pkg::CHAN_CNT_W-1:0];
   endtask

   task automatic load_regs(input idtc_pkg::chan_byte_type tol,
                            input logic [idtc_pkg::CSR_DATA_W-1:0] chans);
      wait_idle();
      write_reg(idtc_pkg::CSR_TOLERANCE, tol);
      write_reg(idtc_pkg::CSR_CHANNELS, chans);
   endtask

   // pixel driver: one beat per pair, random gap after each accepted beat
   always @(posedge clock) begin
      pixel_pair_type px;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap      <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            px.test[0] = req_ch.test_c0;
            px.test[1] = req_ch.test_c1;
            px.test[2] = req_ch.test_c2;
            px.test[3] = req_ch.test_c3;
            px.base[0] = req_ch.base_c0;
            px.base[1] = req_ch.base_c1;
            px.base[2] = req_ch.base_c2;
            px.base[3] = req_ch.base_c3;
            px.eoi     = req_ch.end_of_image;
            expected_results.push_back(compare_pixel(px));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap      <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               px = pixel_queue.pop_front();
               req_ch.test_c0      <= px.test[0];
               req_ch.test_c1      <= px.test[1];
               req_ch.test_c2      <= px.test[2];
               req_ch.test_c3      <= px.test[3];
               req_ch.base_c0      <= px.base[0];
               req_ch.base_c1      <= px.base[1];
               req_ch.base_c2      <= px.base[2];
               req_ch.base_c3      <= px.base[3];
               req_ch.end_of_image <= px.eoi;
               req_ch.valid        <= 1'b1;
               req_gap             <= draw_wait(send_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each beat, then stalls ready at random
   always @(posedge clock) begin
      idtc_pkg::rsp_type want;
      idtc_pkg::rsp_type got;
      int                pause;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.delta[0]          = rsp_ch.delta_c0;
            got.delta[1]          = rsp_ch.delta_c1;
            got.delta[2]          = rsp_ch.delta_c2;
            got.delta[3]          = rsp_ch.delta_c3;
            got.marked[0]         = rsp_ch.marked_c0;
            got.marked[1]         = rsp_ch.marked_c1;
            got.marked[2]         = rsp_ch.marked_c2;
            got.marked[3]         = rsp_ch.marked_c3;
            got.pixel_breach      = rsp_ch.pixel_breach;
            got.image_pass_so_far = rsp_ch.image_pass_so_far;
            got.first_fail_pixel  = rsp_ch.first_fail_pixel;
            got.end_of_image_out  = rsp_ch.end_of_image_out;
            if (expected_results.size() == 0) begin
               $error("result beat with no pixel pending");
               failed = 1'b1;
            end else begin
               want = expected_results.pop_front();
               for (int c = 0; c < idtc_pkg::NUM_CH; c++) begin
                  if (got.delta[c] !== want.delta[c]) begin
                     $error("delta_c%0d: expected %0d, got %0d", c, want.delta[c],
                            got.delta[c]);
                     failed = 1'b1;
                  end
                  if (got.marked[c] !== want.marked[c]) begin
                     $error("marked_c%0d: expected %0d, got %0d", c, want.marked[c],
                            got.marked[c]);
                     failed = 1'b1;
                  end
               end
               if (got.pixel_breach !== want.pixel_breach) begin
                  $error("pixel_breach: expected %0b, got %0b", want.pixel_breach,
                         got.pixel_breach);
                  failed = 1'b1;
               end
               if (got.image_pass_so_far !== want.image_pass_so_far) begin
                  $error("image_pass_so_far: expected %0b, got %0b",
                         want.image_pass_so_far, got.image_pass_so_far);
                  failed = 1'b1;
               end
               if (got.first_fail_pixel !== want.first_fail_pixel) begin
                  $error("first_fail_pixel: expected %0d, got %0d",
                         want.first_fail_pixel, got.first_fail_pixel);
                  failed = 1'b1;
               end
               if (got.end_of_image_out !== want.end_of_image_out) begin
                  $error("end_of_image_out: expected %0b, got %0b",
                         want.end_of_image_out, got.end_of_image_out);
                  failed = 1'b1;
               end
            end
            pause = draw_wait(recv_calm);
            rsp_stall    <= pause;
            rsp_ch.ready <= (pause == 0);
         end else if (rsp_stall > 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_ch.ready <= (rsp_stall == 1);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [idtc_pkg::CSR_DATA_W-1:0] chans;
      idtc_pkg::chan_byte_type         tol;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.test_c0      = '0;
      req_ch.test_c1      = '0;
      req_ch.test_c2      = '0;
      req_ch.test_c3      = '0;
      req_ch.base_c0      = '0;
      req_ch.base_c1      = '0;
      req_ch.base_c2      = '0;
      req_ch.base_c3      = '0;
      req_ch.end_of_image = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero tolerance, all four channels
      add_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
      add_pair(32'hffff_ffff, 32'hffff_ffff, 1'b0);
      add_pair(32'hff00_ff00, 32'h00ff_00ff, 1'b0);
      add_pair(32'h0100_0000, 32'h0000_0000, 1'b0);
      add_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      add_pair(32'h1234_5678, 32'h1234_5678, 1'b1);
      add_pair(32'h0000_0080, 32'h0000_007f, 1'b0);
      add_pair(32'h0000_0000, 32'h0000_0000, 1'b1);

      // widest tolerance: nothing can fail
      load_regs(8'd255, 8'd4);
      add_pair(32'hffff_ffff, 32'h0000_0000, 1'b0);
      add_pair(32'h0000_0000, 32'hffff_ffff, 1'b1);

      // one channel; the others are ignored even when far apart
      load_regs(8'd254, 8'd1);
      add_pair(32'h0000_00ff, 32'h0000_0000, 1'b0);
      add_pair(32'hffff_ff00, 32'h0000_0000, 1'b0);
      add_pair(32'hffff_fffe, 32'h0000_0000, 1'b1);

      // zero channels: all outputs clear, never a breach
      load_regs(8'd0, 8'd0);
      add_pair(32'haaaa_aaaa, 32'h5555_5555, 1'b0);
      add_pair(32'hffff_ffff, 32'h0000_0000, 1'b1);

      // count above four saturates to four
      load_regs(8'd1, 8'd7);
      add_pair(32'h0101_0101, 32'h0000_0000, 1'b0);
      add_pair(32'h0200_0000, 32'h0000_0000, 1'b0);
      add_pair(32'h0000_0000, 32'h0000_0000, 1'b1);

      // random images under a sweep of register settings
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: begin
               tol   = 8'd0;
               chans = 8'd4;
            end
            1: begin
               tol   = 8'd255;
               chans = 8'd1;
            end
            2: begin
               tol   = 8'd0;
               chans = 8'd7;
            end
            3: begin
               tol   = 8'd1;
               chans = 8'd0;
            end
            default: begin
               tol   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 16);
               chans = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(1, 4);
               // junk above the count field
               if ($urandom_range(0, 2) == 0) chans[7:3] = $urandom_range(0, 31);
            end
         endcase
         load_regs(tol, chans);
         if (p == 5) write_reg(CSR_UNMAPPED, $urandom);
         send_calm = ($urandom_range(0, 4) == 0);
         recv_calm = ($urandom_range(0, 4) == 0);
         queue_images(PHASE_PIXELS);
      end

      wait_idle();
      if (failed || expected_results.size() != 0) begin
         $display("TEST FAILED");
      end else begin
         $display("TEST PASSED");
      end
      $finish;
   end

endmodule
